### rtl/ngh_pkg.sv
// Shared types and constants for the noise gate with hold and gain ramp.
package ngh_pkg;

  localparam int SAMPLE_W = 24;
  localparam int MAG_W    = 23;
  localparam int GAIN_W   = 17;
  localparam int ENV_W    = 40;
  localparam int HOLD_W   = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [GAIN_W-1:0] GAIN_ONE  = 17'd65536;
  localparam logic [23:0]       DECAY_Q24 = 24'd16775538;
  localparam logic [MAG_W-1:0]  PEAK_MAX  = 23'd8388607;

  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ATTACK_STEP   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE_STEP  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_FRAMES   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 3'd4;

  typedef struct packed {
    logic [22:0] threshold;
    logic [16:0] attack_step;
    logic [16:0] release_step;
    logic [23:0] hold_frames;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic calc;
  } lane_ctl_t;

  typedef struct packed {
    logic start;
    logic mul_hi;
    logic update;
  } core_ctl_t;

endpackage

### rtl/ngh_lane.sv
// One channel lane: holds its sample, finds its saturated magnitude and applies the gain.
module ngh_lane (
  input  logic                                clk,
  input  ngh_pkg::lane_ctl_t                  ctl,
  input  logic signed [ngh_pkg::SAMPLE_W-1:0] sample_in,
  input  logic        [ngh_pkg::GAIN_W-1:0]   gain,
  output logic        [ngh_pkg::MAG_W-1:0]    mag,
  output logic signed [ngh_pkg::SAMPLE_W-1:0] scaled
);
  import ngh_pkg::*;

  logic signed [SAMPLE_W-1:0] sample_r;
  logic        [MAG_W-1:0]    mag_r;
  logic        [MAG_W-1:0]    mag_nxt;
  logic        [SAMPLE_W-1:0] abs_val;
  logic signed [41:0]         product;

  always_comb begin
    abs_val = sample_r[SAMPLE_W-1] ? SAMPLE_W'(-sample_r) : SAMPLE_W'(sample_r);
    mag_nxt = abs_val[SAMPLE_W-1] ? PEAK_MAX : abs_val[MAG_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      sample_r <= sample_in;
    end
    if (ctl.calc) begin
      mag_r <= mag_nxt;
    end
  end

  // The product of a sample and a gain of at most one always fits 24 bits after the shift.
  assign product = 42'(sample_r) * $signed({25'd0, gain});
  assign scaled  = product[39:16];
  assign mag     = mag_r;

endmodule

### rtl/ngh_core.sv
// Peak merge across lanes, envelope decay, hold counter and gain ramp.
module ngh_core #(
  parameter int NLANES = 2
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  ngh_pkg::core_ctl_t                    ctl,
  input  ngh_pkg::cfg_t                         cfg,
  input  logic [1:0]                            nch,
  input  logic [NLANES-1:0][ngh_pkg::MAG_W-1:0] mags,
  output logic [ngh_pkg::GAIN_W-1:0]            gain,
  output logic                                  is_open
);
  import ngh_pkg::*;

  logic [ENV_W-1:0]  env_r, env_nxt;
  logic [GAIN_W-1:0] gain_r, gain_nxt;
  logic [HOLD_W-1:0] hold_r, hold_nxt;
  logic              open_r, open_nxt;
  logic [43:0]       prod_lo_r, prod_hi_r;
  logic [63:0]       decay_sum;
  logic [ENV_W-1:0]  peak_fx, thr_fx;
  logic [MAG_W-1:0]  peak;
  logic [GAIN_W-1:0] step;
  logic [GAIN_W:0]   gain_sum;

  always_comb begin
    peak = mags[0];
    for (int l = 1; l < NLANES; l++) begin
      if ((2'(l) < nch) && (mags[l] > peak)) begin
        peak = mags[l];
      end
    end

    peak_fx   = {1'b0, peak, 16'd0};
    thr_fx    = {1'b0, cfg.threshold, 16'd0};
    decay_sum = {prod_hi_r, 20'd0} + {20'd0, prod_lo_r};
    env_nxt   = (peak_fx > env_r) ? peak_fx : decay_sum[63:24];

    open_nxt = open_r;
    hold_nxt = hold_r;
    if (env_nxt > thr_fx) begin
      open_nxt = 1'b1;
      hold_nxt = cfg.hold_frames;
    end else if (hold_r != '0) begin
      hold_nxt = hold_r - 1'b1;
    end else begin
      open_nxt = 1'b0;
    end

    gain_nxt = gain_r;
    if (open_nxt) begin
      step     = (cfg.attack_step == '0) ? GAIN_W'(1) : cfg.attack_step;
      gain_sum = {1'b0, gain_r} + {1'b0, step};
      if (gain_r < GAIN_ONE) begin
        gain_nxt = (gain_sum > {1'b0, GAIN_ONE}) ? GAIN_ONE : gain_sum[GAIN_W-1:0];
      end
    end else begin
      step     = (cfg.release_step == '0) ? GAIN_W'(1) : cfg.release_step;
      gain_sum = '0;
      gain_nxt = (gain_r > step) ? gain_r - step : '0;
    end
  end

  // The 40 by 24 bit decay product is split into two 20 bit halves, low half first.
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      prod_lo_r <= 44'(env_r[19:0]) * 44'(DECAY_Q24);
    end
    if (ctl.mul_hi) begin
      prod_hi_r <= 44'(env_r[39:20]) * 44'(DECAY_Q24);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      env_r  <= '0;
      gain_r <= '0;
      hold_r <= '0;
      open_r <= 1'b0;
    end else if (ctl.update) begin
      env_r  <= env_nxt;
      gain_r <= gain_nxt;
      hold_r <= hold_nxt;
      open_r <= open_nxt;
    end
  end

  assign gain    = gain_r;
  assign is_open = open_r;

endmodule

### rtl/noise_gate_hold_ramp_top.sv
// Top level of the noise gate with hold and gain ramp: sequencer, registers and output stage.
//
//   Channel  Direction  Handshake               Payload
//   in_      input      in_valid / in_stall     in_sample_0, in_sample_1
//   out_     output     out_valid / out_stall   out_0, out_1, out_is_open, out_gain_now
//   cfg_     input      cfg_valid / cfg_ready   cfg_index, cfg_data
//
// A frame runs through these steps in order: accept with the low decay product, the high
// decay product with the lane magnitudes, the envelope and gain update, then the lane gain
// multiplies. The split 40 by 24 bit decay multiply puts its two halves in separate steps.
// Reset closes the gate, clears envelope, gain and hold, and restores register defaults.
// A stalled result holds the sequencer in its last step; input is stalled while a frame runs.
module noise_gate_hold_ramp_top #(
  parameter int CHANNELS = 2
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [ngh_pkg::SAMPLE_W-1:0] in_sample_0,
  input  logic signed [ngh_pkg::SAMPLE_W-1:0] in_sample_1,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [ngh_pkg::SAMPLE_W-1:0] out_0,
  output logic signed [ngh_pkg::SAMPLE_W-1:0] out_1,
  output logic                                out_is_open,
  output logic        [ngh_pkg::GAIN_W-1:0]   out_gain_now,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [ngh_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [ngh_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import ngh_pkg::*;

  localparam int NLANES = (CHANNELS < 2) ? CHANNELS : 2;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_MUL   = 2'd1;
  localparam logic [1:0] ST_ENV   = 2'd2;
  localparam logic [1:0] ST_SCALE = 2'd3;

  logic [1:0] state_r, state_nxt;
  cfg_t       cfg_r;
  logic [1:0] chan_cnt_r;
  logic [1:0] nch;
  logic       in_fire, out_load;

  lane_ctl_t lane_ctl;
  core_ctl_t core_ctl;

  logic signed [NLANES-1:0][SAMPLE_W-1:0] lane_in;
  logic signed [NLANES-1:0][SAMPLE_W-1:0] lane_out;
  logic        [NLANES-1:0][MAG_W-1:0]    lane_mag;
  logic [GAIN_W-1:0] gain;
  logic              core_open;

  logic                       out_valid_r;
  logic signed [SAMPLE_W-1:0] out_0_r, out_1_r, out_1_nxt;
  logic                       out_open_r;
  logic [GAIN_W-1:0]          out_gain_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.threshold    <= 23'd8389;
      cfg_r.attack_step  <= GAIN_ONE;
      cfg_r.release_step <= GAIN_ONE;
      cfg_r.hold_frames  <= '0;
      chan_cnt_r         <= 2'd2;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_THRESHOLD:     cfg_r.threshold    <= cfg_data[22:0];
        REG_ATTACK_STEP:   cfg_r.attack_step  <= cfg_data[16:0];
        REG_RELEASE_STEP:  cfg_r.release_step <= cfg_data[16:0];
        REG_HOLD_FRAMES:   cfg_r.hold_frames  <= cfg_data;
        REG_CHANNEL_COUNT: chan_cnt_r         <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (chan_cnt_r)
      2'd0:    nch = 2'd1;
      2'd3:    nch = 2'd2;
      default: nch = chan_cnt_r;
    endcase
    if (nch > 2'(NLANES)) begin
      nch = 2'(NLANES);
    end
  end

  assign in_stall = (state_r != ST_IDLE);
  assign in_fire  = in_valid && !in_stall;
  assign out_load = (state_r == ST_SCALE) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_fire) state_nxt = ST_MUL;
      ST_MUL:   state_nxt = ST_ENV;
      ST_ENV:   state_nxt = ST_SCALE;
      ST_SCALE: if (out_load) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign lane_ctl.load   = in_fire;
  assign lane_ctl.calc   = (state_r == ST_MUL);
  assign core_ctl.start  = in_fire;
  assign core_ctl.mul_hi = (state_r == ST_MUL);
  assign core_ctl.update = (state_r == ST_ENV);

  assign lane_in[0] = in_sample_0;
  if (NLANES > 1) begin : g_second
    assign lane_in[1] = in_sample_1;
    assign out_1_nxt  = (nch >= 2'd2) ? lane_out[1] : '0;
  end else begin : g_mono
    assign out_1_nxt  = '0;
  end

  for (genvar l = 0; l < NLANES; l++) begin : g_lane
    ngh_lane u_lane (
      .clk       (clk),
      .ctl       (lane_ctl),
      .sample_in (lane_in[l]),
      .gain      (gain),
      .mag       (lane_mag[l]),
      .scaled    (lane_out[l])
    );
  end

  ngh_core #(
    .NLANES (NLANES)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (core_ctl),
    .cfg     (cfg_r),
    .nch     (nch),
    .mags    (lane_mag),
    .gain    (gain),
    .is_open (core_open)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_0_r    <= lane_out[0];
      out_1_r    <= out_1_nxt;
      out_open_r <= core_open;
      out_gain_r <= gain;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_0        = out_0_r;
  assign out_1        = out_1_r;
  assign out_is_open  = out_open_r;
  assign out_gain_now = out_gain_r;

endmodule
